/* rtl/svtf_pkg.sv */
// Shared types, codes and widths for the service time FIFO.
package svtf_pkg;

    localparam int ID_W          = 16;
    localparam int TIME_W        = 16;
    localparam int QUERY_W       = 24;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 7;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2,
        OP_FIND = 2'd3
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        RES_NODATA,
        RES_DATA,
        RES_EMPTY,
        RES_FULL
    } res_t;

    typedef struct packed {
        logic load;
        logic write;
        logic drop;
        logic finish;
        res_t res;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic found;
        logic last;
    } dp_stat_t;

endpackage

/* rtl/svtf_ctrl.sv */
// Controller state machine sequencing one queue operation at a time.
module svtf_ctrl
    import svtf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '{load: 1'b0, write: 1'b0, drop: 1'b0, finish: 1'b0, res: RES_NODATA};
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.op)
                    OP_ENQ:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.full)
                        begin
                            cmd.res = RES_FULL;
                        end
                        else
                        begin
                            cmd.write = 1'b1;
                        end
                    end
                    OP_DEQ:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.empty)
                        begin
                            cmd.res = RES_EMPTY;
                        end
                        else
                        begin
                            cmd.drop = 1'b1;
                        end
                    end
                    OP_PEEK:
                    begin
                        cmd.finish = 1'b1;
                        cmd.res    = stat.empty ? RES_EMPTY : RES_DATA;
                    end
                    OP_FIND:
                    begin
                        priority if (stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.res    = RES_EMPTY;
                        end
                        else if (stat.found)
                        begin
                            cmd.finish = 1'b1;
                            cmd.res    = RES_DATA;
                        end
                        else
                        begin
                            cmd.drop = 1'b1;
                            if (stat.last)
                            begin
                                cmd.finish = 1'b1;
                                cmd.res    = RES_EMPTY;
                            end
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                    end
                endcase
                if (cmd.finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next == S_EXEC);
        end
    end

    assign busy = busy_reg;

endmodule

/* rtl/svtf_dpath.sv */
// Datapath: entry memory, ring pointers, running total and result registers.
module svtf_dpath
    import svtf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          op,
    input  logic [ID_W-1:0]     entry_id,
    input  logic [TIME_W-1:0]   service_time,
    input  logic [QUERY_W-1:0]  query_time,
    input  ctrl_cmd_t           cmd,
    output dp_stat_t            stat,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     out_id,
    output logic [TIME_W-1:0]   out_time,
    output logic [OCC_W-1:0]    occupancy
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int TOT_W = TIME_W + CNT_W;
    localparam int CMP_W = (TOT_W > QUERY_W) ? TOT_W : QUERY_W;
    localparam int ENT_W = ID_W + TIME_W;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_reg;

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    op_t                op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [CMP_W-1:0]   query_reg;
    logic [CMP_W-1:0]   total_reg;
    logic [CMP_W-1:0]   sum;

    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic [CNT_W+OCC_W-1:0] occ_ext;

    assign head_next  = !cmd.drop ? head_reg :
                        (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_next  = !cmd.write ? tail_reg :
                        (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign count_next = cmd.write ? count_reg + 1'b1 :
                        cmd.drop  ? count_reg - 1'b1 : count_reg;
    assign occ_ext    = {{OCC_W{1'b0}}, count_next};

    assign sum = total_reg + CMP_W'(rd_reg[TIME_W-1:0]);

    assign stat.op    = op_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.found = (sum >= query_reg);
    assign stat.last  = (count_reg == CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[tail_reg] <= {id_reg, time_reg};
        end
        rd_reg <= mem[head_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(op);
            id_reg    <= entry_id;
            time_reg  <= service_time;
            query_reg <= CMP_W'(query_time);
            total_reg <= '0;
        end
        else if (cmd.drop)
        begin
            total_reg <= sum;
        end
        if (cmd.finish)
        begin
            occ_reg <= occ_ext[OCC_W-1:0];
            unique case (cmd.res)
                RES_DATA:
                begin
                    status_reg   <= ST_OK;
                    out_id_reg   <= rd_reg[ENT_W-1:TIME_W];
                    out_time_reg <= rd_reg[TIME_W-1:0];
                end
                RES_EMPTY:
                begin
                    status_reg   <= ST_EMPTY;
                    out_id_reg   <= '0;
                    out_time_reg <= '0;
                end
                RES_FULL:
                begin
                    status_reg   <= ST_FULL;
                    out_id_reg   <= '0;
                    out_time_reg <= '0;
                end
                default:
                begin
                    status_reg   <= ST_OK;
                    out_id_reg   <= '0;
                    out_time_reg <= '0;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign out_id    = out_id_reg;
    assign out_time  = out_time_reg;
    assign occupancy = occ_reg;

endmodule

/* rtl/service_time_fifo_top.sv */
// Service time FIFO: ring of entries with enqueue, dequeue, peek and find.
// Enqueue, dequeue and peek: accepted, worked in the execute state, result strobe the next
// cycle. Find: removes head entries while the running total stays below the query, up to
// a hit (kept) or an empty queue, then the strobe; one entry read per cycle.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset empties the queue; entry contents stay undefined until written.
module service_time_fifo_top
    import svtf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          op,
    input  logic [ID_W-1:0]     entry_id,
    input  logic [TIME_W-1:0]   service_time,
    input  logic [QUERY_W-1:0]  query_time,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     out_id,
    output logic [TIME_W-1:0]   out_time,
    output logic [OCC_W-1:0]    occupancy
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    svtf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    svtf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .entry_id     (entry_id),
        .service_time (service_time),
        .query_time   (query_time),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .status       (status),
        .out_id       (out_id),
        .out_time     (out_time),
        .occupancy    (occupancy)
    );

endmodule

/* bench/tb_service_time_fifo_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for service_time_fifo_top: directed and random items against a predictor.
module tb_service_time_fifo_top;
    import svtf_pkg::*;

    localparam int SLOTS         = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 800;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_REPORTS   = 40;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } burst_mode_t;

    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    entry_id;
        logic [TIME_W-1:0]  service_time;
        logic [QUERY_W-1:0] query_time;
        logic               wait_drain;
        logic               steady;
    } fifo_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     out_id;
        logic [TIME_W-1:0]   out_time;
        logic [OCC_W-1:0]    occupancy;
    } fifo_reply_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          op;
    logic [ID_W-1:0]     entry_id;
    logic [TIME_W-1:0]   service_time;
    logic [QUERY_W-1:0]  query_time;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [TIME_W-1:0]   out_time;
    logic [OCC_W-1:0]    occupancy;

    fifo_request_t requests_to_send[$];
    fifo_reply_t   awaited_replies[$];
    fifo_request_t on_bus;
    fifo_request_t next_request;
    fifo_reply_t   oldest_reply;
    logic          took;
    int            mismatches;
    int            quiet_cycles;

    logic [ID_W-1:0]   ids_held[SLOTS];
    logic [TIME_W-1:0] times_held[SLOTS];
    int unsigned       head_pos;
    int unsigned       tail_pos;
    int unsigned       held;

    service_time_fifo_top #(
        .DEPTH(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .entry_id(entry_id),
        .service_time(service_time),
        .query_time(query_time),
        .done(done),
        .status(status),
        .out_id(out_id),
        .out_time(out_time),
        .occupancy(occupancy)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic fifo_reply_t serve_item(input fifo_request_t req);
        fifo_reply_t r;
        logic [31:0] total;
        bit          found;
        r     = '0;
        total = '0;
        found = 1'b0;
        r.status = ST_OK;
        case (req.op)
            OP_ENQ:
            begin
                if (held >= SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    ids_held[tail_pos]   = req.entry_id;
                    times_held[tail_pos] = req.service_time;
                    tail_pos = (tail_pos + 1) % SLOTS;
                    held++;
                end
            end
            OP_DEQ:
            begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    head_pos = (head_pos + 1) % SLOTS;
                    held--;
                end
            end
            OP_PEEK:
            begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.out_id   = ids_held[head_pos];
                    r.out_time = times_held[head_pos];
                end
            end
            default:
            begin
                while (held > 0 && !found)
                begin
                    total += 32'(times_held[head_pos]);
                    if (total >= 32'(req.query_time))
                    begin
                        r.out_id   = ids_held[head_pos];
                        r.out_time = times_held[head_pos];
                        found      = 1'b1;
                    end
                    else
                    begin
                        head_pos = (head_pos + 1) % SLOTS;
                        held--;
                    end
                end
                if (!found)
                    r.status = ST_EMPTY;
            end
        endcase
        r.occupancy = OCC_W'(held);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic add_request(input op_t o, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] t, input logic [QUERY_W-1:0] q,
                               input logic drain, input logic steady);
        fifo_request_t req;
        req.op           = o;
        req.entry_id     = id;
        req.service_time = t;
        req.query_time   = q;
        req.wait_drain   = drain;
        req.steady       = steady;
        requests_to_send.push_back(req);
    endtask

    // driver: hold the item until taken, then present the next one or idle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || took)
            begin
                if (requests_to_send.size() > 0
                    && (!requests_to_send[0].wait_drain || awaited_replies.size() == 0)
                    && (requests_to_send[0].steady || $urandom_range(0, 99) >= 24))
                begin
                    next_request = requests_to_send.pop_front();
                    on_bus       <= next_request;
                    op           <= next_request.op;
                    entry_id     <= next_request.entry_id;
                    service_time <= next_request.service_time;
                    query_time   <= next_request.query_time;
                    start        <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: check results against the oldest expectation, predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took <= start && !busy;
            if (done)
            begin
                if (awaited_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: no result expected, actual status %0h id %0h time %0h occ %0h",
                                 $time, status, out_id, out_time, occupancy);
                end
                else
                begin
                    oldest_reply = awaited_replies.pop_front();
                    check_field("status", oldest_reply.status, status);
                    check_field("out_id", oldest_reply.out_id, out_id);
                    check_field("out_time", oldest_reply.out_time, out_time);
                    check_field("occupancy", oldest_reply.occupancy, occupancy);
                end
            end
            if (start && !busy)
                awaited_replies.push_back(serve_item(on_bus));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        burst_mode_t        mode;
        int                 burst;
        int                 k;
        int                 sent;
        int                 roll;
        op_t                o;
        logic [TIME_W-1:0]  t;
        logic [QUERY_W-1:0] q;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_ENQ;
        entry_id     = '0;
        service_time = '0;
        query_time   = '0;
        took         = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        head_pos     = 0;
        tail_pos     = 0;
        held         = 0;

        add_request(OP_PEEK, 16'h0000, 16'h0000, 24'h000000, 1'b0, 1'b0);
        add_request(OP_DEQ,  16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0, 1'b0);
        add_request(OP_FIND, 16'h0000, 16'h0000, 24'h000000, 1'b0, 1'b0);
        add_request(OP_FIND, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b0, 1'b0);
        add_request(OP_ENQ,  16'h0000, 16'h0000, 24'h000000, 1'b0, 1'b0);
        add_request(OP_ENQ,  16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0, 1'b0);
        add_request(OP_ENQ,  16'h1234, 16'h0005, 24'h000000, 1'b0, 1'b0);
        add_request(OP_ENQ,  16'hAAAA, 16'h5555, 24'h000000, 1'b0, 1'b0);
        add_request(OP_PEEK, 16'h0000, 16'h0000, 24'h000000, 1'b0, 1'b0);
        add_request(OP_FIND, 16'h0000, 16'h0000, 24'h000000, 1'b0, 1'b0);
        add_request(OP_FIND, 16'h0000, 16'h0000, 24'h000001, 1'b0, 1'b0);
        add_request(OP_FIND, 16'h0000, 16'h0000, 24'h010004, 1'b0, 1'b0);
        add_request(OP_DEQ,  16'h0000, 16'h0000, 24'h000000, 1'b0, 1'b0);
        add_request(OP_PEEK, 16'h0000, 16'h0000, 24'h000000, 1'b0, 1'b0);
        add_request(OP_FIND, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b0, 1'b0);
        add_request(OP_ENQ,  16'h5555, 16'h0003, 24'h000000, 1'b0, 1'b0);
        add_request(OP_ENQ,  16'h00FF, 16'h0000, 24'h000000, 1'b0, 1'b0);
        add_request(OP_FIND, 16'h0000, 16'h0000, 24'h000003, 1'b0, 1'b0);
        add_request(OP_FIND, 16'h0000, 16'h0000, 24'h000004, 1'b0, 1'b0);
        add_request(OP_PEEK, 16'h0000, 16'h0000, 24'h000000, 1'b0, 1'b0);
        add_request(OP_DEQ,  16'h0000, 16'h0000, 24'h000000, 1'b1, 1'b0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            roll  = $urandom_range(0, 99);
            mode  = (roll < 40) ? MODE_FILL : (roll < 70) ? MODE_DRAIN : MODE_MIX;
            burst = $urandom_range(40, 120);
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:
                        o = (roll < 85) ? OP_ENQ : (roll < 90) ? OP_DEQ :
                            (roll < 95) ? OP_PEEK : OP_FIND;
                    MODE_DRAIN:
                        o = (roll < 20) ? OP_ENQ : (roll < 55) ? OP_DEQ :
                            (roll < 65) ? OP_PEEK : OP_FIND;
                    default:
                        o = (roll < 40) ? OP_ENQ : (roll < 60) ? OP_DEQ :
                            (roll < 75) ? OP_PEEK : OP_FIND;
                endcase
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    t = TIME_W'($urandom);
                else if (roll < 80)
                    t = TIME_W'($urandom_range(0, 15));
                else if (roll < 90)
                    t = '0;
                else
                    t = '1;
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    q = QUERY_W'($urandom_range(0, 300000));
                else if (roll < 50)
                    q = QUERY_W'($urandom_range(0, 64));
                else if (roll < 60)
                    q = '0;
                else if (roll < 70)
                    q = '1;
                else
                    q = QUERY_W'($urandom);
                add_request(o, ID_W'($urandom), t, q, sent == 550, sent >= 300 && sent < 450);
                sent++;
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (requests_to_send.size() > 0 || start || awaited_replies.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        for (k = 0; k < awaited_replies.size(); k++)
            mismatches++;
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
